// ===== rtl/dual_glcd_command_sequencer_assert.svh =====
// Assertion macros for the panel command sequencer
`ifndef DUAL_GLCD_COMMAND_SEQUENCER_ASSERT_SVH
`define DUAL_GLCD_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define DGLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DGLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dglcd_pkg.sv =====
package dglcd_pkg;

  localparam int COLS_PER_CHIP_DEF = 64;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_ADDR   = 3'd1;
  localparam logic [2:0] MODE_WRITE  = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_SHIFT  = 3'd4;

  localparam logic [7:0] CMD_DISPLAY_ON = 8'h3F;
  localparam logic [7:0] CMD_COLUMN     = 8'h40;
  localparam logic [7:0] CMD_PAGE       = 8'hB8;
  localparam logic [7:0] CMD_START      = 8'hC0;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] column;
    logic [2:0] page;
    logic [7:0] data_byte;
    logic [5:0] shift_lines;
  } in_item_t;

  typedef struct packed {
    logic       chip;
    logic       reg_select;
    logic       read_not_write;
    logic [7:0] bus_byte;
    logic       last;
    logic [5:0] scroll_line;
  } out_item_t;

  typedef struct packed {
    logic [2:0] op;
    logic       chip_a;
    logic [7:0] byte_a;
    logic       addr_chip;
    logic [5:0] addr_col;
    logic [2:0] page;
    logic       wrap;
    logic [5:0] shift;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/dual_glcd_command_sequencer.sv =====
// Bus cycle sequencer for a 128x64 panel built from two column controllers.
// Each request (init, set address, write, read, set start line) becomes one
// to four bus cycles on the result queue, the final one flagged by last;
// the block tracks the column with post-increment and re-sends the address
// commands when it wraps onto a controller boundary. The front end takes one
// request per clock while its descriptor queue (QUEUE_DEPTH entries) has room,
// and the back end emits one bus cycle per clock into a single output
// register while that register is empty or popped by out_pop; init and a
// wrapping read give four bus cycles, a plain write one. A request passes
// through the descriptor queue and then the output register before its bus
// cycles appear on out_item. Modes 5 to 7 are taken and dropped with no bus cycle.
module dual_glcd_command_sequencer #(
  parameter int COLS_PER_CHIP = dglcd_pkg::COLS_PER_CHIP_DEF,
  parameter int QUEUE_DEPTH   = dglcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  dglcd_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output dglcd_pkg::out_item_t out_item
);
  import dglcd_pkg::*;

  q_stat_t q_stat;
  desc_t   push_desc;
  desc_t   head_desc;
  logic    q_push;
  logic    q_pop;

  assign in_full = q_stat.full;

  dglcd_front #(
    .COLS_PER_CHIP(COLS_PER_CHIP)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  dglcd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .stat      (q_stat)
  );

  dglcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_desc (head_desc),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/dglcd_front.sv =====
module dglcd_front #(
  parameter int COLS_PER_CHIP = dglcd_pkg::COLS_PER_CHIP_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  dglcd_pkg::in_item_t in_item,
  input  dglcd_pkg::q_stat_t  q_stat,
  output logic                q_push,
  output dglcd_pkg::desc_t    q_desc
);
  import dglcd_pkg::*;

  localparam logic [7:0] CPC_W = 8'(COLS_PER_CHIP);

  logic [6:0] col_r, col_nxt;
  logic [2:0] page_r, page_nxt;
  logic [5:0] shift_r, shift_nxt;
  logic [6:0] inc_col;
  logic       accept;

  function automatic logic owner(input logic [6:0] c);
    return {1'b0, c} >= CPC_W;
  endfunction

  function automatic logic [5:0] local_col(input logic [6:0] c);
    logic [7:0] d;
    d = owner(c) ? ({1'b0, c} - CPC_W) : {1'b0, c};
    return d[5:0];
  endfunction

  assign accept  = in_push && !q_stat.full;
  assign inc_col = col_r + 7'd1;

  always_comb begin
    col_nxt   = col_r;
    page_nxt  = page_r;
    shift_nxt = shift_r;
    q_push    = 1'b0;
    q_desc    = '0;
    q_desc.op = in_item.mode;
    case (in_item.mode)
      MODE_INIT: begin
        col_nxt   = '0;
        page_nxt  = '0;
        shift_nxt = '0;
        q_push    = accept;
      end
      MODE_ADDR: begin
        col_nxt          = in_item.column;
        page_nxt         = in_item.page;
        q_desc.addr_chip = owner(in_item.column);
        q_desc.addr_col  = local_col(in_item.column);
        q_desc.page      = in_item.page;
        q_push           = accept;
      end
      MODE_WRITE, MODE_READ: begin
        col_nxt          = inc_col;
        q_desc.chip_a    = owner(col_r);
        q_desc.byte_a    = in_item.data_byte;
        q_desc.addr_chip = owner(inc_col);
        q_desc.addr_col  = local_col(inc_col);
        q_desc.page      = page_r;
        q_desc.wrap      = (inc_col == 7'd0) || ({1'b0, inc_col} == CPC_W);
        q_push           = accept;
      end
      MODE_SHIFT: begin
        shift_nxt = in_item.shift_lines;
        q_push    = accept;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
    q_desc.shift = shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      page_r  <= '0;
      shift_r <= '0;
    end else if (accept) begin
      col_r   <= col_nxt;
      page_r  <= page_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// ===== rtl/dglcd_queue.sv =====
module dglcd_queue #(
  parameter int QUEUE_DEPTH = dglcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dglcd_pkg::desc_t   push_desc,
  input  logic               pop,
  output dglcd_pkg::desc_t   head_desc,
  output dglcd_pkg::q_stat_t stat
);
  import dglcd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  desc_t         mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = cnt_r == CW'(QUEUE_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/dglcd_back.sv =====
module dglcd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dglcd_pkg::desc_t     head_desc,
  input  dglcd_pkg::q_stat_t   q_stat,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output dglcd_pkg::out_item_t out_item
);
  import dglcd_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  out_item_t  item_r, cyc;
  logic [1:0] base;
  logic [2:0] cnt;
  logic [1:0] aidx;
  logic       last;
  logic       load;

  always_comb begin
    base = 2'd0;
    cnt  = 3'd2;
    case (head_desc.op)
      MODE_INIT:  cnt = 3'd4;
      MODE_ADDR:  cnt = 3'd2;
      MODE_WRITE: begin
        base = 2'd1;
        cnt  = head_desc.wrap ? 3'd3 : 3'd1;
      end
      MODE_READ: begin
        base = 2'd2;
        cnt  = head_desc.wrap ? 3'd4 : 3'd2;
      end
      default: cnt = 3'd2;
    endcase
    aidx = idx_r - base;
    last = {1'b0, idx_r} == (cnt - 3'd1);

    cyc                = '0;
    cyc.last           = last;
    cyc.scroll_line    = head_desc.shift;
    case (head_desc.op)
      MODE_INIT: begin
        cyc.chip     = idx_r[1];
        cyc.bus_byte = idx_r[0] ? (CMD_START | {2'b00, head_desc.shift}) : CMD_DISPLAY_ON;
      end
      MODE_SHIFT: begin
        cyc.chip     = idx_r[0];
        cyc.bus_byte = CMD_START | {2'b00, head_desc.shift};
      end
      default: begin
        if (idx_r < base) begin
          cyc.chip           = head_desc.chip_a;
          cyc.reg_select     = 1'b1;
          cyc.read_not_write = head_desc.op == MODE_READ;
          cyc.bus_byte       = (head_desc.op == MODE_READ) ? 8'h00 : head_desc.byte_a;
        end else begin
          cyc.chip     = head_desc.addr_chip;
          cyc.bus_byte = aidx[0] ? (CMD_PAGE | {5'b00000, head_desc.page})
                                 : (CMD_COLUMN | {2'b00, head_desc.addr_col});
        end
      end
    endcase
  end

  assign load      = !q_stat.empty && (!valid_r || out_pop);
  assign q_pop     = load && last;
  assign idx_nxt   = load ? (last ? 2'd0 : idx_r + 2'd1) : idx_r;
  assign valid_nxt = load || (valid_r && !out_pop);
  assign out_empty = !valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= cyc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== rtl/dglcd_checker.sv =====
`include "dual_glcd_command_sequencer_assert.svh"

module dglcd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_empty,
  input logic                 out_pop,
  input dglcd_pkg::out_item_t out_item
);
  import dglcd_pkg::*;

  `DGLCD_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop,
    !out_empty && $stable(out_item))

  `DGLCD_ASSERT_NOW(a_read_cycle, clk, rst_n, !out_empty && out_item.read_not_write,
    out_item.reg_select && (out_item.bus_byte == 8'h00))

  `DGLCD_ASSERT_NOW(a_start_cmd, clk, rst_n,
    !out_empty && !out_item.reg_select && (out_item.bus_byte[7:6] == 2'b11),
    out_item.bus_byte[5:0] == out_item.scroll_line)

endmodule

bind dual_glcd_command_sequencer dglcd_checker u_chk (.*);
